// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/bcdts_pkg.sv -----
// Types, constants and helper functions for the BCD timestamp converter.
// No dependencies; imported by bcdts_decode and the top-level converter module.
package bcdts_pkg;

  typedef struct packed {
    logic [7:0] yh;
    logic [7:0] yl;
    logic [7:0] mon;
    logic [7:0] day;
    logic [7:0] hr;
    logic [7:0] mi;
    logic [7:0] se;
    logic [2:0] cnt;
  } raw_t;

  typedef struct packed {
    logic        bad;
    logic [13:0] ys;
    logic [6:0]  q100;
    logic [4:0]  q400;
    logic [8:0]  doy;
    logic [6:0]  mday;
    logic [18:0] tod;
  } date_t;

  localparam logic [2:0]         MIN_COUNT    = 3'd4;
  localparam logic [2:0]         FULL_COUNT   = 3'd7;
  localparam logic [14:0]        YEAR_BIAS    = 15'd400;
  localparam logic [22:0]        DAY_BIAS     = 23'd865566;
  localparam logic signed [39:0] SECS_PER_DAY = 40'sd86400;

  function automatic logic bcd_ok(input logic [7:0] b);
    return (b[3:0] <= 4'd9) && (b[7:4] <= 4'd9);
  endfunction

  function automatic logic [6:0] bcd_val(input logic [7:0] b);
    return 7'(b[7:4]) * 7'd10 + 7'(b[3:0]);
  endfunction

  // Floor of x / 25 for x below 3200.
  function automatic logic [6:0] div25(input logic [11:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd1311;
    return p[21:15];
  endfunction

  // Floor of x / 12 for x below 128.
  function automatic logic [3:0] div12(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd171;
    return p[14:11];
  endfunction

  // Day of year of the first of a March-based month.
  function automatic logic [8:0] doy_of(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- hw/rtl/bcdts_decode.sv -----
// Decode stage: BCD check, year/month normalization and time of day.
// Depends on bcdts_pkg.
module bcdts_decode (
  input  bcdts_pkg::raw_t  raw_i,
  output bcdts_pkg::date_t date_o
);
  import bcdts_pkg::*;

  logic        bad;
  logic [13:0] year;
  logic [6:0]  mv;
  logic [6:0]  mm1;
  logic        mzero;
  logic [3:0]  carry;
  logic [3:0]  mon0;
  logic        early;
  logic [3:0]  mp;
  logic [13:0] ys;

  always_comb begin
    bad = (raw_i.cnt < MIN_COUNT) || !bcd_ok(raw_i.yh) || !bcd_ok(raw_i.yl) ||
          !bcd_ok(raw_i.mon) || !bcd_ok(raw_i.day) ||
          ((raw_i.cnt > 3'd4) && !bcd_ok(raw_i.hr)) ||
          ((raw_i.cnt > 3'd5) && !bcd_ok(raw_i.mi)) ||
          ((raw_i.cnt > 3'd6) && !bcd_ok(raw_i.se));

    year  = 14'(raw_i.yh[7:4]) * 14'd1000 + 14'(raw_i.yh[3:0]) * 14'd100 +
            14'(bcd_val(raw_i.yl));
    mv    = bcd_val(raw_i.mon);
    mzero = (mv == 7'd0);
    mm1   = mv - 7'd1;
    carry = mzero ? 4'd0 : div12(mm1);
    mon0  = mzero ? 4'd11 : 4'(mm1 - 7'(carry) * 7'd12);
    early = (mon0 <= 4'd1);
    mp    = early ? mon0 + 4'd10 : mon0 - 4'd2;
    ys    = 14'(15'(year) + YEAR_BIAS + 15'(carry) - 15'(mzero) - 15'(early));

    date_o.bad  = bad;
    date_o.ys   = ys;
    date_o.q100 = div25(ys[13:2]);
    date_o.q400 = 5'(div25(12'(ys[13:4])));
    date_o.doy  = doy_of(mp);
    date_o.mday = bcd_val(raw_i.day);
    date_o.tod  = (raw_i.cnt == FULL_COUNT) ?
                  19'(bcd_val(raw_i.hr)) * 19'd3600 + 19'(bcd_val(raw_i.mi)) * 19'd60 +
                  19'(bcd_val(raw_i.se)) : 19'd0;
  end

endmodule

// ----- hw/rtl/bcd_timestamp_to_epoch_seconds_core.sv -----
// BCD timestamp to epoch seconds converter, top level.
// Throughput: one transaction per cycle unless stalled; four register stages (input,
// decode, day count, result) advance independently, so bubbles collapse under stall.
// Reset: asynchronous, active low; clears all stage valid bits, payload is not reset.
// Depends on bcdts_pkg and bcdts_decode.
module bcd_timestamp_to_epoch_seconds_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [7:0]         year_high_bcd_i,
  input  logic [7:0]         year_low_bcd_i,
  input  logic [7:0]         month_bcd_i,
  input  logic [7:0]         day_bcd_i,
  input  logic [7:0]         hour_bcd_i,
  input  logic [7:0]         minute_bcd_i,
  input  logic [7:0]         second_bcd_i,
  input  logic [2:0]         byte_count_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [38:0] epoch_seconds_o,
  output logic               invalid_o
);
  import bcdts_pkg::*;

  logic               s1_v_q, s2_v_q, s3_v_q, out_v_q;
  raw_t               s1_q;
  date_t              s2_q, s2_d;
  logic signed [22:0] s3_days_q;
  logic [18:0]        s3_tod_q;
  logic               s3_bad_q;
  logic signed [38:0] out_secs_q;
  logic               out_bad_q;

  logic               out_free, s3_free, s2_free, s1_free;
  logic [22:0]        days_pos, days_neg;
  logic signed [23:0] days_w;
  logic signed [39:0] secs_w;

  assign out_free = !out_v_q || !stall_i;
  assign s3_free  = !s3_v_q || out_free;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_free  = !s1_v_q || s2_free;
  assign stall_o  = !s1_free;

  bcdts_decode u_decode (
    .raw_i  (s1_q),
    .date_o (s2_d)
  );

  always_comb begin
    days_pos = 23'(s2_q.ys) * 23'd365 + 23'(s2_q.ys[13:2]) + 23'(s2_q.q400) +
               23'(s2_q.doy) + 23'(s2_q.mday);
    days_neg = 23'(s2_q.q100) + DAY_BIAS;
    days_w   = $signed({1'b0, days_pos}) - $signed({1'b0, days_neg});
    secs_w   = 40'(s3_days_q) * SECS_PER_DAY + $signed({21'b0, s3_tod_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free)  s1_v_q  <= valid_i;
      if (s2_free)  s2_v_q  <= s1_v_q;
      if (s3_free)  s3_v_q  <= s2_v_q;
      if (out_free) out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && valid_i) begin
      s1_q <= '{yh: year_high_bcd_i, yl: year_low_bcd_i, mon: month_bcd_i,
                day: day_bcd_i, hr: hour_bcd_i, mi: minute_bcd_i,
                se: second_bcd_i, cnt: byte_count_i};
    end
    if (s2_free && s1_v_q) begin
      s2_q <= s2_d;
    end
    if (s3_free && s2_v_q) begin
      s3_days_q <= days_w[22:0];
      s3_tod_q  <= s2_q.tod;
      s3_bad_q  <= s2_q.bad;
    end
    if (out_free && s3_v_q) begin
      out_secs_q <= s3_bad_q ? '1 : secs_w[38:0];
      out_bad_q  <= s3_bad_q;
    end
  end

  assign valid_o         = out_v_q;
  assign epoch_seconds_o = out_secs_q;
  assign invalid_o       = out_bad_q;

endmodule

// ----- hw/rtl/bcdts_checker.sv -----
// Port-level checker for the BCD timestamp converter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bcdts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic [2:0]  byte_count_i,
  input logic        valid_o,
  input logic        stall_i,
  input logic [38:0] epoch_seconds_o,
  input logic        invalid_o
);

  logic        short_acc;
  logic        out_inv;
  logic        out_held;
  logic        secs_ones;
  logic [39:0] out_word;

  assign short_acc = valid_i && !stall_o && (byte_count_i < 3'd4);
  assign out_inv   = valid_o && invalid_o;
  assign out_held  = valid_o && stall_i;
  assign secs_ones = &epoch_seconds_o;
  assign out_word  = {epoch_seconds_o, invalid_o};

  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !valid_o, "result valid during reset")

  `ASSERT_CLK(a_invalid_minus_one, clk_i, rst_ni, out_inv |-> secs_ones, "invalid without -1")

  `ASSERT_CLK(a_stall_hold, clk_i, rst_ni, out_held |=> valid_o && $stable(out_word), "stall")

  `ASSERT_CLK(a_short_cnt, clk_i, rst_ni, short_acc ##1 !stall_i[*3] |=> out_inv, "short")

endmodule

bind bcd_timestamp_to_epoch_seconds_core bcdts_checker u_bcdts_checker (.*);
